[hdl/rpps_pkg.sv]
package rpps_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Register widths.
    localparam int DIM_W   = 11;
    localparam int LEVEL_W = 13;
    localparam int PHASE_W = FRAC_BITS;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;

    localparam int COORD_W = 10;
    localparam int COLOR_W = 3;

    // Radius arithmetic.
    localparam int NUM_W  = 23;                       // dx2^2 + dy2^2
    localparam int DEN_W  = 22;                       // W^2 + H^2
    localparam int DIVD_W = NUM_W + 2 * FRAC_BITS;    // dividend and quotient bits
    localparam int Q_W    = DIVD_W + (DIVD_W % 2);    // quotient padded to an even width
    localparam int R_W    = Q_W / 2;                  // radius bits
    localparam int SRM_W  = R_W + 3;                  // square root remainder bits

    localparam int ONE            = 1 << FRAC_BITS;
    localparam int K_THREE_TENTHS = (3 * ONE + 5) / 10;
    localparam int K_RING_WIDTH   = (8 * ONE + 50) / 100;
    localparam int RING_SLOPE     = 25 * (ONE / 4);

    localparam int ACC_W = 2 * FRAC_BITS + 17;

    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_BASS_LEVEL   = 3'd2,
        CFG_MID_LEVEL    = 3'd3,
        CFG_RING_PHASE   = 3'd4,
        CFG_BEAT_FLAG    = 3'd5
    } t_cfg_index;

    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd3;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd7;

endpackage

[hdl/rpps_front.sv]
module rpps_front
    import rpps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [DIM_W-1:0]   i_w,
    input  logic [DIM_W-1:0]   i_h,
    output logic               o_valid,
    output logic [NUM_W-1:0]   o_num
);

    logic signed [DIM_W+1:0] dx2;
    logic signed [DIM_W+1:0] dy2;
    logic [DIM_W-1:0]        n_ax;
    logic [DIM_W-1:0]        n_ay;
    logic [DIM_W-1:0]        r_ax;
    logic [DIM_W-1:0]        r_ay;
    logic                    r_v1;
    logic [NUM_W-1:0]        n_num;
    logic [NUM_W-1:0]        r_num;
    logic                    r_v2;

    // Twice the offset from the centre, so no half pixels appear.
    assign dx2  = $signed({1'b0, i_x, 1'b0}) - $signed({2'b00, i_w});
    assign dy2  = $signed({1'b0, i_y, 1'b0}) - $signed({2'b00, i_h});
    assign n_ax = dx2[DIM_W+1] ? DIM_W'(-dx2) : DIM_W'(dx2);
    assign n_ay = dy2[DIM_W+1] ? DIM_W'(-dy2) : DIM_W'(dy2);
    assign n_num = NUM_W'(r_ax * r_ax) + NUM_W'(r_ay * r_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_num <= n_num;
        end
    end

    assign o_valid = r_v2;
    assign o_num   = r_num;

endmodule

[hdl/rpps_div.sv]
module rpps_div
    import rpps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quot
);

    // One quotient bit per stage; the dividend is num shifted up by 2*FRAC_BITS.
    logic              r_v    [0:DIVD_W];
    logic [NUM_W-1:0]  r_num  [0:DIVD_W];
    logic [DEN_W-1:0]  r_rem  [0:DIVD_W];
    logic [DIVD_W-1:0] r_quot [0:DIVD_W];

    assign r_v[0]    = i_valid;
    assign r_num[0]  = i_num;
    assign r_rem[0]  = '0;
    assign r_quot[0] = '0;

    for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
        logic             dbit;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        if (k < NUM_W) begin : g_num
            assign dbit = r_num[k][NUM_W-1-k];
        end else begin : g_zero
            assign dbit = 1'b0;
        end

        assign trial = {r_rem[k], dbit};
        assign ge    = trial >= {1'b0, i_den};
        assign n_rem = ge ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1]  <= r_num[k];
                r_rem[k+1]  <= n_rem;
                r_quot[k+1] <= {r_quot[k][DIVD_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_v[DIVD_W];
    assign o_quot  = Q_W'(r_quot[DIVD_W]);

endmodule

[hdl/rpps_sqrt.sv]
module rpps_sqrt
    import rpps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [Q_W-1:0]   i_quot,
    output logic             o_valid,
    output logic [R_W-1:0]   o_root
);

    // Digit-by-digit square root, one result bit per stage.
    logic             r_v    [0:R_W];
    logic [Q_W-1:0]   r_q    [0:R_W];
    logic [SRM_W-1:0] r_rem  [0:R_W];
    logic [R_W-1:0]   r_root [0:R_W];

    assign r_v[0]    = i_valid;
    assign r_q[0]    = i_quot;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic [SRM_W-1:0] cur;
        logic [SRM_W-1:0] trial;
        logic             ge;

        assign cur   = {r_rem[k][SRM_W-3:0], r_q[k][Q_W-1-2*k -: 2]};
        assign trial = {1'b0, r_root[k], 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]    <= r_q[k];
                r_rem[k+1]  <= ge ? cur - trial : cur;
                r_root[k+1] <= {r_root[k][R_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_v[R_W];
    assign o_root  = r_root[R_W];

endmodule

[hdl/rpps_shade.sv]
module rpps_shade
    import rpps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [R_W-1:0]     i_radius,
    input  logic [LEVEL_W-1:0] i_bass,
    input  logic [LEVEL_W-1:0] i_mid,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic               i_beat,
    output logic               o_valid,
    output logic [COLOR_W-1:0] o_color
);

    localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_ONE >>> 1;
    localparam logic signed [ACC_W-1:0] ACC_QTR  = ACC_ONE >>> 2;
    localparam logic signed [ACC_W-1:0] ACC_3QTR = ACC_HALF + ACC_QTR;
    localparam logic signed [ACC_W-1:0] BEAT_ADD = ACC_W'(K_THREE_TENTHS * ONE);

    // Stage A: one minus radius, ring distance and ring term.
    logic signed [R_W+1:0]  n_omr;
    logic [R_W-1:0]         ring_dist;
    logic signed [R_W+1:0]  r_omr;
    logic signed [ACC_W-1:0] n_ring;
    logic signed [ACC_W-1:0] r_ring_a;
    logic                   r_va;

    assign n_omr = $signed((R_W+2)'(ONE)) - $signed({2'b00, i_radius});
    assign ring_dist = (i_radius >= R_W'(i_phase)) ? i_radius - R_W'(i_phase)
                                                   : R_W'(i_phase) - i_radius;
    assign n_ring = (ring_dist < R_W'(K_RING_WIDTH))
                  ? ACC_HALF - $signed(ACC_W'(ring_dist[9:0] * RING_SLOPE))
                  : '0;

    // Stage B: products.
    logic signed [ACC_W-1:0] r_bass_term;
    logic signed [ACC_W-1:0] r_mid_term;
    logic signed [ACC_W-1:0] r_ring_b;
    logic                    r_vb;

    // Stage C: sum, clamp and palette.
    logic signed [ACC_W-1:0] acc;
    logic [COLOR_W-1:0]      n_color;
    logic [COLOR_W-1:0]      r_color;
    logic                    r_vc;

    always_comb begin
        acc = r_bass_term + r_mid_term + r_ring_b + (i_beat ? BEAT_ADD : '0);
        if (acc < ACC_QTR) begin
            n_color = COLOR_BLACK;
        end else if (acc < ACC_HALF) begin
            n_color = COLOR_RED;
        end else if (acc < ACC_3QTR) begin
            n_color = COLOR_YELLOW;
        end else begin
            n_color = COLOR_WHITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_omr       <= n_omr;
            r_ring_a    <= n_ring;
            r_bass_term <= ACC_W'($signed({1'b0, i_bass}) * r_omr);
            r_mid_term  <= $signed(ACC_W'(i_mid * K_THREE_TENTHS));
            r_ring_b    <= r_ring_a;
            r_color     <= n_color;
        end
    end

    assign o_valid = r_vc;
    assign o_color = r_color;

endmodule

[hdl/radial_pulse_pixel_shader.sv]
// Channel       Direction  Transaction contents
// s_axis_*      in         one pixel coordinate (pixel_x, pixel_y)
// m_axis_*      out        one palette colour (color_index)
// i_cfg_*       in         register write, no handshake
//
// One pixel enters per clock while the output is not stalled; its colour
// passes through the squared distance, the long division (one quotient
// bit per stage), the square root (one bit per stage) and the shading.
// Reset is synchronous and active low; it empties the pipeline and loads
// the register defaults. A stall on the output freezes every stage at
// once, so no pixel is lost or repeated.
module radial_pulse_pixel_shader
    import rpps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // [9:0] pixel_x, [19:10] pixel_y, zeros above
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [2:0] color_index, zeros above
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // Configuration registers.
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [LEVEL_W-1:0] r_bass;
    logic [LEVEL_W-1:0] r_mid;
    logic [PHASE_W-1:0] r_phase;
    logic               r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(80);
            r_height <= DIM_W'(48);
            r_bass   <= LEVEL_W'(2048);
            r_mid    <= LEVEL_W'(1228);
            r_phase  <= '0;
            r_beat   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_BASS_LEVEL:   r_bass   <= i_cfg_data[LEVEL_W-1:0];
                CFG_MID_LEVEL:    r_mid    <= i_cfg_data[LEVEL_W-1:0];
                CFG_RING_PHASE:   r_phase  <= i_cfg_data[PHASE_W-1:0];
                CFG_BEAT_FLAG:    r_beat   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize saturates. The
    // squared diagonal is registered; configuration must change only while
    // the pipeline is empty (the block does not enforce it), so the lag is harmless.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DEN_W-1:0] r_den;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= DEN_W'(w_eff * w_eff) + DEN_W'(h_eff * h_eff);
    end

    // The whole pipeline advances together whenever the output register
    // is free or being emptied.
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic             front_v;
    logic [NUM_W-1:0] front_num;
    logic             div_v;
    logic [Q_W-1:0]   div_q;
    logic             sq_v;
    logic [R_W-1:0]   sq_r;
    logic [COLOR_W-1:0] color;

    rpps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_x     (s_axis_tdata[9:0]),
        .i_y     (s_axis_tdata[19:10]),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .o_valid (front_v),
        .o_num   (front_num)
    );

    rpps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_num   (front_num),
        .i_den   (r_den),
        .o_valid (div_v),
        .o_quot  (div_q)
    );

    rpps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_quot  (div_q),
        .o_valid (sq_v),
        .o_root  (sq_r)
    );

    rpps_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (sq_v),
        .i_radius (sq_r),
        .i_bass   (r_bass),
        .i_mid    (r_mid),
        .i_phase  (r_phase),
        .i_beat   (r_beat),
        .o_valid  (m_axis_tvalid),
        .o_color  (color)
    );

    assign m_axis_tdata = {5'b00000, color};

endmodule
